@@ rtl/ppm_frame_decoder_top_assert.svh @@
// assertion macros for the ppm frame decoder checker
`ifndef PPM_FRAME_DECODER_TOP_ASSERT_SVH
`define PPM_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PPMFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppm frame decoder check failed");

// next-cycle implication, disabled while reset is low
`define PPMFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppm frame decoder check failed");

`endif

@@ rtl/ppmfd_pkg.sv @@
// shared constants for the ppm frame decoder
package ppmfd_pkg;

    // channel count default, legal range 1 to 15
    localparam int NUM_CHANNELS_DEF = 8;

    localparam int TIME_W   = 16;
    localparam int CHAN_W   = 4;
    localparam int MODE_W   = 2;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // transaction modes
    localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SYNC_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_PULSE_MIN      = 2'd1;
    localparam logic [1:0] REG_PULSE_MAX      = 2'd2;

    // register reset values
    localparam logic [TIME_W-1:0] SYNC_THRESHOLD_RST = 16'd8000;
    localparam logic [TIME_W-1:0] PULSE_MIN_RST      = 16'd750;
    localparam logic [TIME_W-1:0] PULSE_MAX_RST      = 16'd2500;

endpackage

@@ rtl/ppm_frame_decoder_top.sv @@
// ppm frame decoder: interval capture, slot store, supervisor and channel reads
// reads: a read transaction accepted into the input register is loaded into the output
//   register once that register has room, and its result is shown from there
// throughput: one transaction per cycle; only a read waiting on a stalled output
//   register holds the input register, everything else retires without waiting
// reset: synchronous active-low; clears config to defaults, all channel state,
//   and both valid flags
module ppm_frame_decoder_top
    import ppmfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_capture_time,
    input  logic [CHAN_W-1:0]     i_channel,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TIME_W-1:0]     o_channel_width,
    output logic                  o_read_error
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [TIME_W-1:0] r_sync_threshold;
    logic [TIME_W-1:0] r_pulse_min;
    logic [TIME_W-1:0] r_pulse_max;
    logic              w_cfg_wr;
    logic [1:0]        w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_threshold <= SYNC_THRESHOLD_RST;
            r_pulse_min      <= PULSE_MIN_RST;
            r_pulse_max      <= PULSE_MAX_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_SYNC_THRESHOLD: r_sync_threshold <= pwdata[TIME_W-1:0];
                REG_PULSE_MIN:      r_pulse_min      <= pwdata[TIME_W-1:0];
                REG_PULSE_MAX:      r_pulse_max      <= pwdata[TIME_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    // read data: registers zero-extended, unmapped reads as zero
    always_comb begin
        unique case (w_cfg_idx)
            REG_SYNC_THRESHOLD: prdata = {{(APB_DATA_W-TIME_W){1'b0}}, r_sync_threshold};
            REG_PULSE_MIN:      prdata = {{(APB_DATA_W-TIME_W){1'b0}}, r_pulse_min};
            REG_PULSE_MAX:      prdata = {{(APB_DATA_W-TIME_W){1'b0}}, r_pulse_max};
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic              r_in_valid;
    logic [MODE_W-1:0] r_mode;
    logic [TIME_W-1:0] r_capture_time;
    logic [CHAN_W-1:0] r_channel;

    // ---------------------------------------------------------------
    // decoder state
    // ---------------------------------------------------------------
    logic [TIME_W-1:0]       r_last_timestamp, n_last_timestamp;
    logic [CHAN_W-1:0]       r_slot_index,     n_slot_index;
    logic [TIME_W-1:0]       r_width_store [NUM_CHANNELS];
    logic [TIME_W-1:0]       n_width_store [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_updated,        n_updated;
    logic                    r_phase,          n_phase;

    // output register
    logic              r_out_valid,     n_out_valid;
    logic [TIME_W-1:0] r_channel_width, n_channel_width;
    logic              r_read_error,    n_read_error;

    logic              w_out_free;
    logic              w_advance;
    logic              w_load_out;
    logic [TIME_W-1:0] w_gap;
    logic              w_sync_gap;
    logic              w_pulse_ok;
    logic              w_slot_free;

    // output register can take a new result when empty or draining this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    // only a read needs room at the output; other modes always retire
    assign w_advance  = r_in_valid && ((r_mode != MODE_READ) || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_load_out = w_advance && (r_mode == MODE_READ);

    // interval with timer wrap: no increase means 0xffff - prev + now,
    // which never exceeds 16 bits so plain modulo arithmetic is exact
    assign w_gap = (r_capture_time > r_last_timestamp)
                 ? (r_capture_time - r_last_timestamp)
                 : (~r_last_timestamp + r_capture_time);

    assign w_sync_gap  = w_gap > r_sync_threshold;
    assign w_pulse_ok  = (w_gap > r_pulse_min) && (w_gap < r_pulse_max);
    assign w_slot_free = r_slot_index < CHAN_W'(NUM_CHANNELS);

    always_comb begin
        n_last_timestamp = r_last_timestamp;
        n_slot_index     = r_slot_index;
        n_width_store    = r_width_store;
        n_updated        = r_updated;
        n_phase          = r_phase;
        n_channel_width  = r_channel_width;
        n_read_error     = r_read_error;
        n_out_valid      = r_out_valid && i_out_stall;

        if (w_advance) begin
            unique case (r_mode)
                MODE_CAPTURE: begin
                    n_last_timestamp = r_capture_time;
                    if (w_sync_gap) begin
                        // frame sync gap restarts the slot sequence
                        n_slot_index = '0;
                    end else if (w_pulse_ok && w_slot_free) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (r_slot_index == CHAN_W'(i)) begin
                                n_width_store[i] = w_gap;
                                n_updated[i]     = 1'b1;
                            end
                        end
                        n_slot_index = r_slot_index + 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (!r_phase) begin
                        // even tick: open a new observation window
                        n_updated = '0;
                    end else begin
                        // odd tick: drop channels not refreshed in the window
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (!r_updated[i]) begin
                                n_width_store[i] = '0;
                            end
                        end
                    end
                    n_phase = !r_phase;
                end
                MODE_READ: begin
                    // out-of-range channel matches no entry and reads as zero
                    n_channel_width = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (r_channel == CHAN_W'(i)) begin
                            n_channel_width = r_width_store[i];
                        end
                    end
                    n_read_error = r_channel >= CHAN_W'(NUM_CHANNELS);
                    n_out_valid  = 1'b1;
                end
                default: ;  // unused mode, no effect
            endcase
        end
    end

    // control and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_last_timestamp <= '0;
            r_slot_index     <= '0;
            r_updated        <= '0;
            r_phase          <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_width_store[i] <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid      <= n_out_valid;
            r_last_timestamp <= n_last_timestamp;
            r_slot_index     <= n_slot_index;
            r_updated        <= n_updated;
            r_phase          <= n_phase;
            r_width_store    <= n_width_store;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode         <= i_mode;
            r_capture_time <= i_capture_time;
            r_channel      <= i_channel;
        end
        if (w_load_out) begin
            r_channel_width <= n_channel_width;
            r_read_error    <= n_read_error;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_width = r_channel_width;
    assign o_read_error    = r_read_error;

endmodule

@@ rtl/ppmfd_checker.sv @@
// port-level checker for the ppm frame decoder, bound to the top level
`include "ppm_frame_decoder_top_assert.svh"

module ppmfd_checker
    import ppmfd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [TIME_W-1:0]     o_channel_width,
    input logic                  o_read_error
);

    logic                w_err_out;
    logic                w_out_held;
    logic [TIME_W:0]     w_out_pay;
    logic                w_map_wr;
    logic                w_rd_ok;
    logic [TIME_W-1:0]   r_wr_lo;

    assign w_err_out  = o_out_valid && o_read_error;
    assign w_out_held = o_out_valid && i_out_stall;
    assign w_out_pay  = {o_channel_width, o_read_error};
    assign w_map_wr   = psel && penable && pwrite
                      && (paddr[APB_ADDR_W-1:2] == REG_SYNC_THRESHOLD
                          || paddr[APB_ADDR_W-1:2] == REG_PULSE_MIN
                          || paddr[APB_ADDR_W-1:2] == REG_PULSE_MAX);
    assign w_rd_ok    = prdata == {{(APB_DATA_W-TIME_W){1'b0}}, r_wr_lo};

    // low half of the data bus from the previous cycle
    always_ff @(posedge i_clk) begin
        r_wr_lo <= pwdata[TIME_W-1:0];
    end

    // a read beyond the channel range never carries a width
    `PPMFD_ASSERT_NOW(a_error_zero_width, i_clk, i_rst_n, w_err_out, o_channel_width == '0)

    // input side only backs up behind a stalled, full output register
    `PPMFD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, w_out_held)

    // a stalled result transaction holds its payload
    `PPMFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_out_valid && $stable(w_out_pay))

    // reset empties the output register
    `PPMFD_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

    // a mapped register reads back the low half of what was written
    `PPMFD_ASSERT_NOW(a_cfg_readback, i_clk, i_rst_n, w_map_wr ##1 $stable(paddr), w_rd_ok)

endmodule

bind ppm_frame_decoder_top ppmfd_checker u_ppmfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_channel_width (o_channel_width),
    .o_read_error    (o_read_error)
);

@@ dv/ppm_frame_decoder_checker.sv @@
// checker for the ppm frame decoder: mirrors decoder state and compares read results
module ppm_frame_decoder_checker
    import ppmfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_capture_time,
    input  logic [CHAN_W-1:0]     i_channel,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [TIME_W-1:0]     i_channel_width,
    input  logic                  i_read_error,
    output int                    o_mismatches,
    output int                    o_reads_owed
);

    typedef struct packed {
        logic [TIME_W-1:0] width;
        logic              error;
    } t_read_result;

    logic [TIME_W-1:0]       sync_thr;
    logic [TIME_W-1:0]       min_pulse;
    logic [TIME_W-1:0]       max_pulse;
    logic [TIME_W-1:0]       prev_stamp;
    logic [CHAN_W-1:0]       slot;
    logic [TIME_W-1:0]       widths [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] marks;
    logic                    tick_phase;
    t_read_result            reads_owed [$];

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                   input logic [TIME_W-1:0] got);
        o_mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    task automatic take_capture(input logic [TIME_W-1:0] now);
        int interval;
        // no increase means the timer wrapped, equal stamps give the full span
        if (now > prev_stamp)
            interval = int'(now) - int'(prev_stamp);
        else
            interval = 32'hFFFF - int'(prev_stamp) + int'(now);
        prev_stamp = now;
        if (interval > sync_thr) begin
            slot = '0;
        end else if (interval > min_pulse && interval < max_pulse && slot < NUM_CHANNELS) begin
            widths[slot] = interval[TIME_W-1:0];
            marks[slot]  = 1'b1;
            slot         = slot + 1'b1;
        end
    endtask

    task automatic take_tick();
        if (!tick_phase) begin
            marks = '0;
        end else begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                if (!marks[i])
                    widths[i] = '0;
        end
        tick_phase = ~tick_phase;
    endtask

    task automatic take_read(input logic [CHAN_W-1:0] chan);
        t_read_result res;
        if (chan < NUM_CHANNELS) begin
            res.width = widths[chan];
            res.error = 1'b0;
        end else begin
            res.width = '0;
            res.error = 1'b1;
        end
        reads_owed.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_read_result want;
        if (!i_rst_n) begin
            sync_thr   = SYNC_THRESHOLD_RST;
            min_pulse  = PULSE_MIN_RST;
            max_pulse  = PULSE_MAX_RST;
            prev_stamp = '0;
            slot       = '0;
            marks      = '0;
            tick_phase = 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
                widths[i] = '0;
            reads_owed.delete();
        end else begin
            // results first: a read never shows up at the edge that accepts it
            if (i_out_valid && !i_out_stall) begin
                if (reads_owed.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected result, expected none, actual width 0x%0h error %0b",
                             $time, i_channel_width, i_read_error);
                end else begin
                    want = reads_owed.pop_front();
                    if (i_channel_width !== want.width)
                        report_mismatch("channel_width", want.width, i_channel_width);
                    if (i_read_error !== want.error)
                        report_mismatch("read_error", TIME_W'(want.error),
                                        TIME_W'(i_read_error));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    MODE_CAPTURE: take_capture(i_capture_time);
                    MODE_TICK:    take_tick();
                    MODE_READ:    take_read(i_channel);
                    default: ;
                endcase
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_SYNC_THRESHOLD: sync_thr  = pwdata[TIME_W-1:0];
                    REG_PULSE_MIN:      min_pulse = pwdata[TIME_W-1:0];
                    REG_PULSE_MAX:      max_pulse = pwdata[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
        o_reads_owed = reads_owed.size();
    end

endmodule

@@ dv/tb_top.sv @@
// testbench top for the ppm frame decoder: stimulus, flow control and verdict
module tb_top;
    import ppmfd_pkg::*;

    localparam int NCH          = NUM_CHANNELS_DEF;
    // mode code the block has no use for
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // receiver hold-off long enough to fill both register stages
    localparam int HOLD_CYCLES  = 120;
    // drain margin: a read result passes the input register and then the output register
    localparam int DRAIN_CYCLES = 6;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [MODE_W-1:0]     i_mode         = MODE_CAPTURE;
    logic [TIME_W-1:0]     i_capture_time = '0;
    logic [CHAN_W-1:0]     i_channel      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [TIME_W-1:0]     o_channel_width;
    logic                  o_read_error;

    int mismatches;
    int reads_pending;

    // stimulus-side copy of the register settings, only used to shape intervals
    logic [TIME_W-1:0] cfg_sync = SYNC_THRESHOLD_RST;
    logic [TIME_W-1:0] cfg_min  = PULSE_MIN_RST;
    logic [TIME_W-1:0] cfg_max  = PULSE_MAX_RST;
    // last timestamp handed to the block; matches its reset value at start
    logic [TIME_W-1:0] cur_stamp = '0;

    int burst_left;
    int items_sent;
    bit hold_req;

    ppm_frame_decoder_top #(
        .NUM_CHANNELS(NCH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_capture_time (i_capture_time),
        .i_channel      (i_channel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel_width(o_channel_width),
        .o_read_error   (o_read_error)
    );

    ppm_frame_decoder_checker #(
        .NUM_CHANNELS(NCH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_capture_time (i_capture_time),
        .i_channel      (i_channel),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_channel_width(o_channel_width),
        .i_read_error   (o_read_error),
        .o_mismatches   (mismatches),
        .o_reads_owed   (reads_pending)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the block hangs on a handshake
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver side: runs of random stall density, fully open runs included,
    // and one long hold-off when the stimulus asks for it
    initial begin
        int run_left;
        int stall_pct;
        int hold_left;
        run_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                i_out_stall = 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(4, 32);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
                run_left--;
                i_out_stall = ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // one transaction on the input channel; the sender works in bursts with
    // idle gaps of random length between them
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] stamp,
                             input logic [CHAN_W-1:0] chan);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            repeat (idle) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_mode         = mode;
        i_capture_time = stamp;
        i_channel      = chan;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic capture_at(input logic [TIME_W-1:0] stamp);
        send_item(MODE_CAPTURE, stamp, CHAN_W'($urandom));
        cur_stamp = stamp;
    endtask

    // capture whose interval from the last one is the given span
    task automatic capture_gap(input int span);
        logic [TIME_W-1:0] nxt;
        // across the wrap the block's interval is one short of the modular difference
        if (span > 0 && int'(cur_stamp) + span <= 32'hFFFF)
            nxt = cur_stamp + span[TIME_W-1:0];
        else
            nxt = cur_stamp + span[TIME_W-1:0] + 1'b1;
        capture_at(nxt);
    endtask

    task automatic read_channel(input logic [CHAN_W-1:0] chan);
        send_item(MODE_READ, TIME_W'($urandom), chan);
    endtask

    function automatic int sync_gap();
        int lo;
        lo = int'(cfg_sync) + 1;
        // sometimes exactly the threshold, which is not a sync
        if ($urandom_range(0, 9) == 0)
            return cfg_sync;
        if (lo <= 32'hFFFF)
            return $urandom_range(32'hFFFF, lo);
        return $urandom_range(32'hFFFF, 0);
    endfunction

    function automatic int pulse_gap();
        int lo;
        int hi;
        lo = int'(cfg_min) + 1;
        hi = int'(cfg_max) - 1;
        // band edges are excluded, hit them now and then
        case ($urandom_range(0, 19))
            0: return cfg_min;
            1: return cfg_max;
            default: ;
        endcase
        if (hi >= lo)
            return $urandom_range(hi, lo);
        return $urandom_range(32'hFFFF, 0);
    endfunction

    // mostly well-formed frames (sync then a run of pulses, sometimes more
    // than there are slots) mixed with reads, ticks, noise and unused codes
    task automatic random_traffic(input int count);
        int first;
        int kind;
        int pulses;
        first = items_sent;
        while (items_sent - first < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                capture_gap(sync_gap());
                pulses = $urandom_range(0, NCH + 2);
                repeat (pulses) begin
                    capture_gap(pulse_gap());
                    if ($urandom_range(0, 5) == 0)
                        read_channel(CHAN_W'($urandom_range(0, NCH - 1)));
                end
            end else if (kind < 70) begin
                if ($urandom_range(0, 3) == 0)
                    read_channel(CHAN_W'($urandom_range(NCH, 15)));
                else
                    read_channel(CHAN_W'($urandom_range(0, NCH - 1)));
            end else if (kind < 80) begin
                send_item(MODE_TICK, TIME_W'($urandom), CHAN_W'($urandom));
            end else if (kind < 93) begin
                capture_at(TIME_W'($urandom));
            end else begin
                send_item(MODE_UNUSED, TIME_W'($urandom), CHAN_W'($urandom));
            end
        end
    endtask

    // drop valid and wait until every read result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (reads_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(input logic [1:0] index, input logic [TIME_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = {{(APB_DATA_W - TIME_W){1'b0}}, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (index)
            REG_SYNC_THRESHOLD: cfg_sync = value;
            REG_PULSE_MIN:      cfg_min  = value;
            REG_PULSE_MAX:      cfg_max  = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [TIME_W-1:0] sync_val, input logic [TIME_W-1:0] min_val,
                             input logic [TIME_W-1:0] max_val);
        wait_idle();
        write_reg(REG_SYNC_THRESHOLD, sync_val);
        write_reg(REG_PULSE_MIN, min_val);
        write_reg(REG_PULSE_MAX, max_val);
    endtask

    initial begin
        logic [TIME_W-1:0] rnd_min;
        burst_left = 0;
        items_sent = 0;
        hold_req   = 1'b0;

        // synchronous reset held low, then released at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, registers at their reset values
        read_channel(4'd0);
        read_channel(4'd15);
        // equal timestamps: wrap rule gives the full span, a sync
        capture_at(16'h0000);
        capture_gap(751);
        capture_gap(2499);
        // exactly on the band edges: ignored
        capture_gap(750);
        capture_gap(2500);
        // exactly on the sync threshold: neither sync nor pulse
        capture_gap(8000);
        capture_gap(8001);
        capture_gap(1200);
        // timer wrap from the top of the range
        capture_at(16'hFFFF);
        capture_at(16'd1000);
        read_channel(4'd0);
        read_channel(4'd1);
        // unused mode code with every field at its top
        send_item(MODE_UNUSED, 16'hFFFF, 4'hF);
        // even tick clears the marks, odd tick zeroes stale channels
        send_item(MODE_TICK, '0, '0);
        capture_gap(1600);
        send_item(MODE_TICK, 16'hFFFF, 4'hF);
        read_channel(4'd0);
        read_channel(4'd1);
        read_channel(CHAN_W'(NCH - 1));
        read_channel(CHAN_W'(NCH));

        random_traffic(100);

        // widest band, sync impossible
        configure(16'hFFFF, 16'h0000, 16'hFFFF);
        random_traffic(60);

        // every nonzero interval syncs, the band is empty
        configure(16'h0000, 16'hFFFF, 16'h0000);
        random_traffic(30);

        rnd_min = TIME_W'($urandom_range(300, 1200));
        configure(TIME_W'($urandom_range(3000, 12000)), rnd_min,
                  rnd_min + TIME_W'($urandom_range(200, 2500)));
        random_traffic(50);

        // receiver holds off while reads keep coming back to back, then the
        // sender pauses until every result is in
        hold_req   = 1'b1;
        burst_left = 40;
        repeat (24) read_channel(CHAN_W'($urandom_range(0, 15)));
        wait_idle();
        random_traffic(40);

        configure(SYNC_THRESHOLD_RST, PULSE_MIN_RST, PULSE_MAX_RST);
        random_traffic(40);

        wait_idle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
